>>> rtl/clst_pkg.sv
// Shared types, constants and helpers for the client login session table.
// Used by every module of the block; no dependencies of its own.
package clst_pkg;

  localparam int SLOT_COUNT   = 16;
  localparam int CLIENT_WIDTH = 32;
  localparam int ID_W         = 32;
  localparam int KEY_W        = (CLIENT_WIDTH < ID_W) ? CLIENT_WIDTH : ID_W;
  localparam int IDX_W        = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int USED_W       = 4;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [KEY_W-1:0] key_t;

  typedef enum logic [2:0] {
    ACT_LOGIN     = 3'd0,
    ACT_CHECK     = 3'd1,
    ACT_LOGOUT    = 3'd2,
    ACT_LOGOUT_ALL = 3'd3,
    ACT_PIN_CHANGE = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_PIN_BAD   = 2'd1,
    ST_NO_SLOT   = 2'd2,
    ST_FORBIDDEN = 2'd3
  } status_e;

  // Stored role codes (requested role plus one, zero is empty)
  localparam logic [1:0] ROLE_NONE         = 2'd0;
  localparam logic [1:0] ROLE_SO_STORED    = 2'd2;
  localparam logic [1:0] ROLE_WHEEL_STORED = 2'd3;
  // Requested role codes
  localparam logic [1:0] REQ_ROLE_USER     = 2'd0;
  localparam logic [1:0] REQ_ROLE_INVALID  = 2'd3;

  // Search state handed from cell to cell
  typedef struct packed {
    logic       valid;
    key_t       id;
    logic       live_hit;
    idx_t       live_idx;
    logic [1:0] live_role;
    logic       free_hit;
    idx_t       free_idx;
  } carry_t;

  // Table update broadcast from the sequencer to every cell
  typedef struct packed {
    logic       wr;
    logic       clr;
    logic       clr_all;
    idx_t       idx;
    key_t       id;
    logic [1:0] role;
  } apply_t;

  // Keep the low bits of a slot index for the result field
  function automatic logic [USED_W-1:0] to_used(idx_t i);
    logic [7:0] w;
    w = 8'(i);
    return w[USED_W-1:0];
  endfunction

endpackage

>>> rtl/clst_cell.sv
// One slot of the session table: stored handle and role, plus one search stage.
// Depends on clst_pkg for the carry and update structs.
module clst_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  clst_pkg::idx_t  idx_i,
  input  clst_pkg::carry_t carry_i,
  input  clst_pkg::apply_t apply_i,
  output clst_pkg::carry_t carry_o
);

  clst_pkg::key_t   client_q;
  logic [1:0]       role_q, role_d;
  clst_pkg::carry_t carry_q, carry_d;
  logic             live, empty, hit_me;

  // Compare this slot against the passing request
  assign live   = (role_q != clst_pkg::ROLE_NONE) && (client_q == carry_i.id);
  assign empty  = (role_q == clst_pkg::ROLE_NONE);
  assign hit_me = (apply_i.idx == idx_i);

  // Record the first live match and the first free slot
  always_comb begin
    carry_d = carry_i;
    if (!carry_i.live_hit && live) begin
      carry_d.live_hit  = 1'b1;
      carry_d.live_idx  = idx_i;
      carry_d.live_role = role_q;
    end
    if (!carry_i.free_hit && empty) begin
      carry_d.free_hit = 1'b1;
      carry_d.free_idx = idx_i;
    end
  end

  // Apply updates addressed to this slot
  always_comb begin
    role_d = role_q;
    if (apply_i.wr && hit_me) begin
      role_d = apply_i.role;
    end
    if ((apply_i.clr && hit_me) || apply_i.clr_all) begin
      role_d = clst_pkg::ROLE_NONE;
    end
  end

  // Advance the role and the search stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      role_q  <= clst_pkg::ROLE_NONE;
      carry_q <= '0;
    end else begin
      role_q  <= role_d;
      carry_q <= carry_d;
    end
  end

  // Handle storage, no reset
  always_ff @(posedge clk_i) begin
    if (apply_i.wr && hit_me) begin
      client_q <= apply_i.id;
    end
  end

  assign carry_o = carry_q;

endmodule

>>> rtl/clst_ctrl.sv
// Request sequencer: latches a request, waits for the search to leave the
// chain, decides the outcome, updates the table and holds the result.
// Depends on clst_pkg.
module clst_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [2:0]       action_i,
  input  logic [31:0]      client_id_i,
  input  logic [1:0]       role_i,
  input  logic             pin_match_i,
  output clst_pkg::carry_t launch_o,
  input  clst_pkg::carry_t tail_i,
  output clst_pkg::apply_t apply_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [1:0]       status_o,
  output logic [3:0]       slot_used_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_HOLD
  } state_e;

  state_e     state_q;
  logic [2:0] action_q;
  logic [1:0] role_q;
  logic       pin_q;
  logic       out_valid_q;
  logic [1:0] status_q, pend_status_q, status_d;
  logic [3:0] used_q, pend_used_q, used_d;
  logic       accept, done;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign done       = (state_q == S_SEARCH) && tail_i.valid;

  // Inject a fresh search into the head of the chain
  always_comb begin
    launch_o           = '0;
    launch_o.valid     = accept;
    launch_o.id        = clst_pkg::KEY_W'(client_id_i);
  end

  // Decide the outcome from the finished search
  always_comb begin
    status_d       = clst_pkg::ST_FORBIDDEN;
    used_d         = '0;
    apply_o        = '0;
    apply_o.id     = tail_i.id;
    apply_o.role   = 2'(role_q + 2'd1);
    case (action_q)
      clst_pkg::ACT_LOGIN: begin
        if (role_q == clst_pkg::REQ_ROLE_INVALID) begin
          status_d = clst_pkg::ST_FORBIDDEN;
        end else if (!pin_q) begin
          status_d = clst_pkg::ST_PIN_BAD;
        end else if (tail_i.live_hit) begin
          status_d    = clst_pkg::ST_OK;
          used_d      = clst_pkg::to_used(tail_i.live_idx);
          apply_o.wr  = done;
          apply_o.idx = tail_i.live_idx;
        end else if (tail_i.free_hit) begin
          status_d    = clst_pkg::ST_OK;
          used_d      = clst_pkg::to_used(tail_i.free_idx);
          apply_o.wr  = done;
          apply_o.idx = tail_i.free_idx;
        end else begin
          status_d = clst_pkg::ST_NO_SLOT;
        end
      end
      clst_pkg::ACT_CHECK: begin
        if (tail_i.live_hit &&
            ({1'b0, tail_i.live_role} == (3'({1'b0, role_q}) + 3'd1))) begin
          status_d = clst_pkg::ST_OK;
          used_d   = clst_pkg::to_used(tail_i.live_idx);
        end
      end
      clst_pkg::ACT_LOGOUT: begin
        status_d = clst_pkg::ST_OK;
        if (tail_i.live_hit) begin
          used_d      = clst_pkg::to_used(tail_i.live_idx);
          apply_o.clr = done;
          apply_o.idx = tail_i.live_idx;
        end
      end
      clst_pkg::ACT_LOGOUT_ALL: begin
        status_d        = clst_pkg::ST_OK;
        apply_o.clr_all = done;
      end
      clst_pkg::ACT_PIN_CHANGE: begin
        if (tail_i.live_hit &&
            ((tail_i.live_role == clst_pkg::ROLE_WHEEL_STORED) ||
             ((role_q == clst_pkg::REQ_ROLE_USER) &&
              (tail_i.live_role == clst_pkg::ROLE_SO_STORED)))) begin
          status_d = clst_pkg::ST_OK;
          used_d   = clst_pkg::to_used(tail_i.live_idx);
        end
      end
      default: begin
        status_d = clst_pkg::ST_FORBIDDEN;
      end
    endcase
  end

  // Sequence the request and hold the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      out_valid_q   <= 1'b0;
      action_q      <= '0;
      role_q        <= '0;
      pin_q         <= 1'b0;
      status_q      <= '0;
      used_q        <= '0;
      pend_status_q <= '0;
      pend_used_q   <= '0;
    end else begin
      // Load a waiting result, or drop the result once the receiver takes it
      if ((state_q == S_HOLD) && (!out_valid_q || !out_stall_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            action_q <= action_i;
            role_q   <= role_i;
            pin_q    <= pin_match_i;
            state_q  <= S_SEARCH;
          end
        end
        S_SEARCH: begin
          if (done) begin
            pend_status_q <= status_d;
            pend_used_q   <= used_d;
            state_q       <= S_HOLD;
          end
        end
        S_HOLD: begin
          if (!out_valid_q || !out_stall_i) begin
            status_q    <= pend_status_q;
            used_q      <= pend_used_q;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign slot_used_o = used_q;

endmodule

>>> rtl/client_login_session_table_core.sv
// Client login session table: a row of slot cells and the request sequencer.
// Depends on clst_pkg, clst_cell and clst_ctrl.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one request: action,
//   client handle, requested role and the PIN comparison flag. Output
//   channel (out_valid_o / out_stall_i) returns one status and slot index
//   per request, in request order.
//   A transfer happens on a rising edge with valid high and stall low.
//   Requests are handled one at a time. After a request transfers, its
//   search walks the slot cells one per cycle, then the sequencer decides
//   the outcome and loads the result into the output register; the next
//   request can transfer once that result has been loaded.
//   Table updates (login, logout, logout all) take effect when the search
//   finishes, before the result is shown.
//   When the receiver stalls, the result holds in the output register; a
//   following request may still transfer and its result waits internally.
//   Reset empties every slot at once and clears both channels.
module client_login_session_table_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  action_i,
  input  logic [31:0] client_id_i,
  input  logic [1:0]  role_i,
  input  logic        pin_match_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [3:0]  slot_used_o
);

  clst_pkg::carry_t carry [clst_pkg::SLOT_COUNT+1];
  clst_pkg::apply_t apply;

  clst_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .action_i    (action_i),
    .client_id_i (client_id_i),
    .role_i      (role_i),
    .pin_match_i (pin_match_i),
    .launch_o    (carry[0]),
    .tail_i      (carry[clst_pkg::SLOT_COUNT]),
    .apply_o     (apply),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .slot_used_o (slot_used_o)
  );

  // Build the row of slot cells
  for (genvar k = 0; k < clst_pkg::SLOT_COUNT; k++) begin : g_cell
    clst_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .idx_i   (clst_pkg::idx_t'(k)),
      .carry_i (carry[k]),
      .apply_i (apply),
      .carry_o (carry[k+1])
    );
  end

endmodule

>>> rtl/clst_checker.sv
// Port-level checks for the client login session table core.
// Depends on clst_pkg; bound to client_login_session_table_core below.
module clst_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [1:0] status_o,
  input logic [3:0] slot_used_o
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(status_o) && $stable(slot_used_o))
    else $error("stalled result changed");

  // Failed requests name no slot
  a_fail_no_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ((status_o == clst_pkg::ST_PIN_BAD) ||
                    (status_o == clst_pkg::ST_NO_SLOT) ||
                    (status_o == clst_pkg::ST_FORBIDDEN)) |-> slot_used_o == 4'd0)
    else $error("failed request reports a slot");

  // One request in flight: stall right after a transfer
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second request taken during search");

endmodule

bind client_login_session_table_core clst_checker u_clst_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .status_o    (status_o),
  .slot_used_o (slot_used_o)
);

>>> verif/client_login_session_table_core_tb.sv
// Self-checking bench for the client login session table core.
// Depends on clst_pkg and client_login_session_table_core; predicts each reply.
`timescale 1ns / 1ps

module client_login_session_table_core_tb;

  localparam int CLK_HALF    = 5;
  localparam int RESET_LEN   = 6;
  localparam int RAND_ITEMS  = 1000;
  localparam int POOL_SIZE   = 24;
  localparam int CALM_START  = 3000;
  localparam int CALM_END    = 6000;
  localparam int HOLD_START  = 1500;
  localparam int HOLD_LEN    = 400;
  localparam int LATENCY     = clst_pkg::SLOT_COUNT + 2;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [2:0]  action;
    logic [31:0] client;
    logic [1:0]  role;
    logic        pin;
  } login_req_t;

  typedef struct packed {
    clst_pkg::status_e           status;
    logic [clst_pkg::USED_W-1:0] slot;
  } login_reply_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  status;
  logic [3:0]  slot_used;
  login_req_t  cur_req = '0;

  login_req_t     requests_todo[$];
  login_reply_t   replies_due[$];
  clst_pkg::key_t tbl_client[clst_pkg::SLOT_COUNT];
  logic [1:0]     tbl_role[clst_pkg::SLOT_COUNT];
  logic [31:0]    id_pool[POOL_SIZE];
  int             cycles = 0;
  int             rx_cycles = 0;
  int             errors = 0;

  client_login_session_table_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .action_i    (cur_req.action),
    .client_id_i (cur_req.client),
    .role_i      (cur_req.role),
    .pin_match_i (cur_req.pin),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .status_o    (status),
    .slot_used_o (slot_used)
  );

  // Clock
  always begin
    #CLK_HALF clk_i = 1'b1;
    #CLK_HALF clk_i = 1'b0;
  end

  // Random idling, switched off inside the calm window
  function automatic bit idle_now();
    if (cycles >= CALM_START && cycles < CALM_END) return 1'b0;
    return $urandom_range(0, 99) < 31;
  endfunction

  // Apply one request to the shadow table and return its reply
  function automatic login_reply_t session_result(login_req_t rq);
    clst_pkg::key_t id;
    int             live;
    int             free_slot;
    int             s;
    login_reply_t   r;
    id = rq.client[clst_pkg::KEY_W-1:0];
    r.status = clst_pkg::ST_FORBIDDEN;
    r.slot = '0;
    live = -1;
    free_slot = -1;
    // Scan downward so the lowest matching slot wins
    for (int i = clst_pkg::SLOT_COUNT - 1; i >= 0; i--) begin
      if (tbl_role[i] != clst_pkg::ROLE_NONE && tbl_client[i] == id) live = i;
      if (tbl_role[i] == clst_pkg::ROLE_NONE) free_slot = i;
    end
    case (rq.action)
      clst_pkg::ACT_LOGIN: begin
        if (rq.role == clst_pkg::REQ_ROLE_INVALID) begin
          r.status = clst_pkg::ST_FORBIDDEN;
        end else if (!rq.pin) begin
          r.status = clst_pkg::ST_PIN_BAD;
        end else begin
          s = (live >= 0) ? live : free_slot;
          if (s < 0) begin
            r.status = clst_pkg::ST_NO_SLOT;
          end else begin
            tbl_client[s] = id;
            tbl_role[s] = rq.role + 2'd1;
            r.status = clst_pkg::ST_OK;
            r.slot = clst_pkg::USED_W'(s);
          end
        end
      end
      clst_pkg::ACT_CHECK: begin
        if (live >= 0 && rq.role != clst_pkg::REQ_ROLE_INVALID &&
            tbl_role[live] == rq.role + 2'd1) begin
          r.status = clst_pkg::ST_OK;
          r.slot = clst_pkg::USED_W'(live);
        end
      end
      clst_pkg::ACT_LOGOUT: begin
        if (live >= 0) begin
          tbl_role[live] = clst_pkg::ROLE_NONE;
          r.slot = clst_pkg::USED_W'(live);
        end
        r.status = clst_pkg::ST_OK;
      end
      clst_pkg::ACT_LOGOUT_ALL: begin
        for (int i = 0; i < clst_pkg::SLOT_COUNT; i++) tbl_role[i] = clst_pkg::ROLE_NONE;
        r.status = clst_pkg::ST_OK;
      end
      clst_pkg::ACT_PIN_CHANGE: begin
        if (live >= 0 && (tbl_role[live] == clst_pkg::ROLE_WHEEL_STORED ||
            (rq.role == clst_pkg::REQ_ROLE_USER &&
             tbl_role[live] == clst_pkg::ROLE_SO_STORED))) begin
          r.status = clst_pkg::ST_OK;
          r.slot = clst_pkg::USED_W'(live);
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic add_req(logic [2:0] act, logic [31:0] client, logic [1:0] role, logic pin);
    login_req_t rq;
    rq.action = act;
    rq.client = client;
    rq.role = role;
    rq.pin = pin;
    requests_todo.push_back(rq);
  endtask

  // Driver: predict on each input transfer, then offer the next request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) replies_due.push_back(session_result(cur_req));
      if (!in_valid || !in_stall) begin
        if (requests_todo.size() != 0 && !idle_now()) begin
          cur_req <= requests_todo.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls plus one long hold-off to back up the block
  always @(posedge clk_i) begin
    rx_cycles <= rx_cycles + 1;
    out_stall <= (rx_cycles >= HOLD_START && rx_cycles < HOLD_START + HOLD_LEN) || idle_now();
  end

  // Monitor: compare each output transfer with the oldest reply due
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) begin
      if (replies_due.size() == 0) begin
        $display("%0t: unexpected reply status %0d slot %0d", $time, status, slot_used);
        errors++;
      end else begin
        login_reply_t exp_r;
        exp_r = replies_due.pop_front();
        if (status !== exp_r.status) begin
          $display("%0t: status expected %0d actual %0d", $time, exp_r.status, status);
          errors++;
        end
        if (slot_used !== exp_r.slot) begin
          $display("%0t: slot_used expected %0d actual %0d", $time, exp_r.slot, slot_used);
          errors++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int r;
    logic [31:0] id;
    for (int i = 0; i < clst_pkg::SLOT_COUNT; i++) begin
      tbl_client[i] = '0;
      tbl_role[i] = clst_pkg::ROLE_NONE;
    end
    id_pool[0] = '0;
    id_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) id_pool[i] = $urandom;

    // Directed: field extremes, every action and the corner cases
    add_req(clst_pkg::ACT_LOGIN, 32'h0, clst_pkg::REQ_ROLE_INVALID, 1'b1);
    add_req(clst_pkg::ACT_LOGIN, 32'h0, clst_pkg::REQ_ROLE_USER, 1'b0);
    add_req(clst_pkg::ACT_LOGIN, 32'h0, clst_pkg::REQ_ROLE_USER, 1'b1);
    add_req(clst_pkg::ACT_LOGIN, 32'hFFFF_FFFF, 2'd2, 1'b1);
    add_req(clst_pkg::ACT_CHECK, 32'h0, clst_pkg::REQ_ROLE_USER, 1'b0);
    add_req(clst_pkg::ACT_LOGIN, 32'h0, 2'd1, 1'b1);
    add_req(clst_pkg::ACT_CHECK, 32'h0, 2'd1, 1'b1);
    add_req(clst_pkg::ACT_CHECK, 32'h0, clst_pkg::REQ_ROLE_USER, 1'b1);
    add_req(clst_pkg::ACT_CHECK, 32'hFFFF_FFFF, clst_pkg::REQ_ROLE_INVALID, 1'b1);
    add_req(clst_pkg::ACT_PIN_CHANGE, 32'h0, clst_pkg::REQ_ROLE_USER, 1'b0);
    add_req(clst_pkg::ACT_PIN_CHANGE, 32'h0, 2'd1, 1'b1);
    add_req(clst_pkg::ACT_PIN_CHANGE, 32'hFFFF_FFFF, 2'd1, 1'b0);
    add_req(clst_pkg::ACT_PIN_CHANGE, 32'h1234_5678, clst_pkg::REQ_ROLE_USER, 1'b1);
    add_req(clst_pkg::ACT_CHECK, 32'h1234_5678, clst_pkg::REQ_ROLE_USER, 1'b1);
    add_req(clst_pkg::ACT_LOGOUT, 32'h0, clst_pkg::REQ_ROLE_INVALID, 1'b1);
    add_req(clst_pkg::ACT_LOGOUT, 32'h0, clst_pkg::REQ_ROLE_USER, 1'b0);
    add_req(clst_pkg::ACT_LOGIN, 32'h8000_0001, clst_pkg::REQ_ROLE_USER, 1'b1);
    add_req(clst_pkg::ACT_PIN_CHANGE + 3'd1, 32'hFFFF_FFFF, clst_pkg::REQ_ROLE_USER, 1'b1);
    add_req(clst_pkg::ACT_PIN_CHANGE + 3'd2, 32'h0, 2'd2, 1'b0);
    add_req(clst_pkg::ACT_PIN_CHANGE + 3'd3, 32'hFFFF_FFFF, clst_pkg::REQ_ROLE_INVALID, 1'b1);
    add_req(clst_pkg::ACT_LOGOUT_ALL, 32'hFFFF_FFFF, clst_pkg::REQ_ROLE_INVALID, 1'b1);
    add_req(clst_pkg::ACT_CHECK, 32'hFFFF_FFFF, 2'd2, 1'b1);

    // Random: logins most often, over a small client pool so the table fills up
    for (int n = 0; n < RAND_ITEMS; n++) begin
      login_req_t rq;
      r = $urandom_range(0, 99);
      if (r < 40) rq.action = clst_pkg::ACT_LOGIN;
      else if (r < 62) rq.action = clst_pkg::ACT_CHECK;
      else if (r < 74) rq.action = clst_pkg::ACT_LOGOUT;
      else if (r < 76) rq.action = clst_pkg::ACT_LOGOUT_ALL;
      else if (r < 93) rq.action = clst_pkg::ACT_PIN_CHANGE;
      else rq.action = clst_pkg::ACT_PIN_CHANGE + 3'($urandom_range(1, 3));
      id = ($urandom_range(0, 99) < 90) ? id_pool[$urandom_range(0, POOL_SIZE - 1)] : $urandom;
      rq.client = id;
      rq.role = ($urandom_range(0, 99) < 10) ? clst_pkg::REQ_ROLE_INVALID :
                2'($urandom_range(0, 2));
      rq.pin = $urandom_range(0, 99) < 85;
      requests_todo.push_back(rq);
    end

    // Reset, then wait for every request to go in and every reply to come out
    repeat (RESET_LEN) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (requests_todo.size() != 0 || in_valid) @(posedge clk_i);
    while (replies_due.size() != 0) @(posedge clk_i);
    repeat (2 * LATENCY) @(posedge clk_i);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
